### src/pwmcp_pkg.sv
// ----------------------------------------------------------------------------
// pwmcp_pkg
// Shared types and constants of the PWM text command parser: the command and
// status bundles between controller and datapath, and the ASCII codes used.
// ----------------------------------------------------------------------------
package pwmcp_pkg;

   localparam int LINE_BYTES_DEFAULT = 64;

   // Largest duty percentage that a SET command may carry, and the value at
   // which digit accumulation saturates.
   localparam logic [6:0] DUTY_MAX = 7'd100;
   localparam logic [6:0] DUTY_SAT = 7'd101;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_VT  = 8'h0B;
   localparam logic [7:0] CH_FF  = 8'h0C;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_0   = 8'h30;

   // Controller to datapath.
   typedef struct packed {
      logic       store;      // write the received byte into the line store
      logic       start;      // line end: latch duty and rewind the scan
      logic       scan_en;    // advance the line scan and the parser
      logic       clear_len;  // empty the line store after the scan
      logic       load;       // load the result register with one character
      logic       last;       // this character ends the response
      logic [2:0] emit_idx;   // position of the character in the response
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic       len_zero;   // nothing stored in the line
      logic       scan_done;  // parser has reached its verdict
      logic [2:0] resp_count; // number of response characters, zero if none
   } status_type;

endpackage

### src/pwmcp_dp.sv
// ----------------------------------------------------------------------------
// pwmcp_dp
// Datapath: line store memory and fill count, the pipelined line scan, the
// character-level command parser, the decimal conversion of the readback and
// the result register.
// ----------------------------------------------------------------------------
module pwmcp_dp #(
   parameter int LINE_BYTES = pwmcp_pkg::LINE_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pwmcp_pkg::cmd_type     cmd,
   output pwmcp_pkg::status_type  status,
   input  logic [15:0]            req_tdata,
   output logic [15:0]            rsp_tdata,
   output logic [0:0]             rsp_tuser,
   output logic                   rsp_tlast
);
   import pwmcp_pkg::*;

   localparam int AW = $clog2(LINE_BYTES);
   localparam logic [AW-1:0] LEN_LIMIT = AW'(LINE_BYTES - 1);

   typedef enum logic [3:0] {
      P_LEAD, P_KW1, P_KW2, P_SEP1, P_WS1, P_PW1, P_PW2, P_PWM,
      P_WS2, P_DIG, P_TAIL, P_FAIL
   } pstate_type;

   typedef enum logic [1:0] {
      R_NONE, R_EMPTY, R_OK, R_GET
   } kind_type;

   logic [7:0] line_mem [LINE_BYTES];

   logic [AW-1:0] len_ff, len_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [7:0]    rd_data_ff;
   logic          nul_seen_ff, nul_seen_in;
   pstate_type    pstate_ff, pstate_in;
   logic          is_get_ff, is_get_in;
   logic [6:0]    acc_ff, acc_in;
   logic [7:0]    duty_ff, duty_in;

   logic          has_byte_ff;
   logic [7:0]    tx_byte_ff;
   logic          strobe_ff;
   logic [6:0]    value_ff;
   logic          last_ff;

   logic          stop, issue, feed, wr_en;
   logic [7:0]    ch, chu;
   logic          ch_ws, ch_dig;
   logic [3:0]    ch_val;
   logic [9:0]    acc_next;
   kind_type      kind;
   logic [2:0]    count;
   logic [7:0]    rsp_char;
   logic [2:0]    get_pos;
   logic [1:0]    hund;
   logic [7:0]    rem;
   logic [14:0]   tens_prod;
   logic [3:0]    tens, ones;

   function automatic logic [7:0] upper(input logic [7:0] c);
      if (c >= "a" && c <= "z") begin
         return c - 8'd32;
      end
      return c;
   endfunction

   // Line store: written while bytes arrive, read one entry a cycle by the scan.
   assign wr_en = cmd.store && (len_ff != LEN_LIMIT);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[len_ff] <= req_tdata[7:0];
      end
      if (issue) begin
         rd_data_ff <= line_mem[rd_addr_ff];
      end
   end

   // Scan control: one read in flight, the parser takes the byte in the cycle after the read.
   assign stop   = nul_seen_ff || (pstate_ff == P_FAIL);
   assign issue  = cmd.scan_en && !stop && (rd_addr_ff != len_ff);
   assign feed   = cmd.scan_en && !stop && rd_pend_ff && (rd_data_ff != CH_NUL);

   assign ch     = rd_data_ff;
   assign chu    = upper(ch);
   assign ch_ws  = (ch inside {CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR, CH_LF});
   assign ch_dig = (ch >= CH_0) && (ch <= CH_0 + 8'd9);
   assign ch_val = 4'(ch - CH_0);
   assign acc_next = 10'(acc_ff) * 10'd10 + 10'(ch_val);

   always_comb begin
      len_in      = len_ff;
      rd_addr_in  = rd_addr_ff;
      rd_pend_in  = rd_pend_ff;
      nul_seen_in = nul_seen_ff;
      pstate_in   = pstate_ff;
      is_get_in   = is_get_ff;
      acc_in      = acc_ff;
      duty_in     = duty_ff;

      if (wr_en) begin
         len_in = len_ff + AW'(1);
      end
      if (cmd.clear_len) begin
         len_in = '0;
      end

      if (cmd.start) begin
         rd_addr_in  = '0;
         rd_pend_in  = 1'b0;
         nul_seen_in = 1'b0;
         pstate_in   = P_LEAD;
         is_get_in   = 1'b0;
         acc_in      = '0;
         duty_in     = req_tdata[15:8];
      end else if (cmd.scan_en) begin
         rd_pend_in = issue;
         if (issue) begin
            rd_addr_in = rd_addr_ff + AW'(1);
         end
         if (cmd.scan_en && !stop && rd_pend_ff && (rd_data_ff == CH_NUL)) begin
            nul_seen_in = 1'b1;
         end
         if (feed) begin
            case (pstate_ff)
               P_LEAD: begin
                  if (ch_ws) begin
                     pstate_in = P_LEAD;
                  end else if (chu == "S") begin
                     pstate_in = P_KW1;
                     is_get_in = 1'b0;
                  end else if (chu == "G") begin
                     pstate_in = P_KW1;
                     is_get_in = 1'b1;
                  end else begin
                     pstate_in = P_FAIL;
                  end
               end
               P_KW1:  pstate_in = (chu == "E") ? P_KW2 : P_FAIL;
               P_KW2:  pstate_in = (chu == "T") ? P_SEP1 : P_FAIL;
               P_SEP1: pstate_in = ch_ws ? P_WS1 : P_FAIL;
               P_WS1: begin
                  if (ch_ws) begin
                     pstate_in = P_WS1;
                  end else begin
                     pstate_in = (chu == "P") ? P_PW1 : P_FAIL;
                  end
               end
               P_PW1:  pstate_in = (chu == "W") ? P_PW2 : P_FAIL;
               P_PW2:  pstate_in = (chu == "M") ? P_PWM : P_FAIL;
               P_PWM: begin
                  if (!ch_ws) begin
                     pstate_in = P_FAIL;
                  end else begin
                     pstate_in = is_get_ff ? P_TAIL : P_WS2;
                  end
               end
               P_WS2: begin
                  if (ch_ws) begin
                     pstate_in = P_WS2;
                  end else if (ch_dig) begin
                     pstate_in = P_DIG;
                     acc_in    = 7'(ch_val);
                  end else begin
                     pstate_in = P_FAIL;
                  end
               end
               P_DIG: begin
                  if (ch_dig) begin
                     acc_in = (acc_next > 10'(DUTY_MAX)) ? DUTY_SAT : 7'(acc_next);
                  end else if (ch_ws) begin
                     pstate_in = P_TAIL;
                  end else begin
                     pstate_in = P_FAIL;
                  end
               end
               P_TAIL:  pstate_in = ch_ws ? P_TAIL : P_FAIL;
               default: pstate_in = P_FAIL;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         rd_addr_ff  <= '0;
         rd_pend_ff  <= 1'b0;
         nul_seen_ff <= 1'b0;
         pstate_ff   <= P_LEAD;
         is_get_ff   <= 1'b0;
         acc_ff      <= '0;
      end else begin
         len_ff      <= len_in;
         rd_addr_ff  <= rd_addr_in;
         rd_pend_ff  <= rd_pend_in;
         nul_seen_ff <= nul_seen_in;
         pstate_ff   <= pstate_in;
         is_get_ff   <= is_get_in;
         acc_ff      <= acc_in;
      end
      duty_ff <= duty_in;
   end

   // Verdict of the parser once the scan has stopped.
   always_comb begin
      if (pstate_ff == P_LEAD) begin
         kind = R_EMPTY;
      end else if (is_get_ff && (pstate_ff inside {P_PWM, P_TAIL})) begin
         kind = R_GET;
      end else if (!is_get_ff && (pstate_ff inside {P_DIG, P_TAIL})
                   && (acc_ff <= DUTY_MAX)) begin
         kind = R_OK;
      end else begin
         kind = R_NONE;
      end
   end

   // Decimal digits of the readback: hundreds by compare, tens by reciprocal.
   assign hund      = (duty_ff >= 8'd200) ? 2'd2 : (duty_ff >= 8'd100) ? 2'd1 : 2'd0;
   assign rem       = duty_ff - 8'(hund) * 8'd100;
   assign tens_prod = 15'(rem[6:0]) * 15'd205;
   assign tens      = tens_prod[14:11];
   assign ones      = 4'(rem - 8'(tens) * 8'd10);

   always_comb begin
      case (kind)
         R_EMPTY: count = 3'd5;
         R_OK:    count = 3'd4;
         R_GET:   count = (duty_ff >= 8'd100) ? 3'd5 : (duty_ff >= 8'd10) ? 3'd4 : 3'd3;
         default: count = 3'd0;
      endcase
   end

   assign get_pos = cmd.emit_idx + (3'd5 - count);

   always_comb begin
      rsp_char = CH_NUL;
      case (kind)
         R_EMPTY: begin
            case (cmd.emit_idx)
               3'd0:    rsp_char = "e";
               3'd1:    rsp_char = "m";
               3'd2:    rsp_char = "p";
               3'd3:    rsp_char = "t";
               default: rsp_char = "y";
            endcase
         end
         R_OK: begin
            case (cmd.emit_idx)
               3'd0:    rsp_char = "O";
               3'd1:    rsp_char = "K";
               3'd2:    rsp_char = CH_CR;
               default: rsp_char = CH_LF;
            endcase
         end
         R_GET: begin
            case (get_pos)
               3'd0:    rsp_char = CH_0 + 8'(hund);
               3'd1:    rsp_char = CH_0 + 8'(tens);
               3'd2:    rsp_char = CH_0 + 8'(ones);
               3'd3:    rsp_char = CH_CR;
               default: rsp_char = CH_LF;
            endcase
         end
         default: rsp_char = CH_NUL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         has_byte_ff <= 1'b1;
         tx_byte_ff  <= rsp_char;
         strobe_ff   <= (kind == R_OK) && (cmd.emit_idx == 3'd0);
         value_ff    <= ((kind == R_OK) && (cmd.emit_idx == 3'd0)) ? acc_ff : 7'd0;
         last_ff     <= cmd.last;
      end
   end

   assign status.len_zero   = (len_ff == '0);
   assign status.scan_done  = stop || ((rd_addr_ff == len_ff) && !rd_pend_ff);
   assign status.resp_count = count;

   assign rsp_tdata = {value_ff, strobe_ff, tx_byte_ff};
   assign rsp_tuser = has_byte_ff;
   assign rsp_tlast = last_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_LIMIT)
      else $error("line fill count beyond the store");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_en |-> (rd_addr_ff <= len_ff))
      else $error("scan address passed the end of the line");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (value_ff <= DUTY_MAX))
      else $error("set value beyond the largest duty");

endmodule

### src/pwmcp_ctrl.sv
// ----------------------------------------------------------------------------
// pwmcp_ctrl
// Controller: takes bytes, starts and waits for the line scan, and paces the
// response characters into the result register.
// ----------------------------------------------------------------------------
module pwmcp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            rx_byte,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output pwmcp_pkg::cmd_type    cmd,
   input  pwmcp_pkg::status_type status
);
   import pwmcp_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE, S_SCAN, S_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] idx_ff, idx_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic       accept, eol, slot_free;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign eol        = (rx_byte == CH_CR) || (rx_byte == CH_LF);
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      cmd           = '0;
      cmd.emit_idx  = idx_ff;
      cmd.last      = (idx_ff == status.resp_count - 3'd1);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!eol) begin
                  cmd.store = 1'b1;
               end else if (!status.len_zero) begin
                  cmd.start = 1'b1;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_en = 1'b1;
            if (status.scan_done) begin
               cmd.clear_len = 1'b1;
               idx_in        = '0;
               state_in      = (status.resp_count == 3'd0) ? S_IDLE : S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               cmd.load      = 1'b1;
               rsp_tvalid_in = 1'b1;
               idx_in        = idx_ff + 3'd1;
               if (cmd.last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (idx_ff < status.resp_count))
      else $error("response index beyond the response length");

   a_clear_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && status.scan_done) |=> status.len_zero)
      else $error("line not emptied after the scan");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && cmd.last) |=> (state_ff == S_IDLE && rsp_tvalid_ff))
      else $error("controller kept emitting after the final character");

endmodule

### src/pwm_text_command_parser.sv
// ----------------------------------------------------------------------------
// pwm_text_command_parser
// Line-oriented text command parser for a PWM duty setting: SET PWM n and
// GET PWM over a byte stream, with ASCII responses.
// ----------------------------------------------------------------------------
// Each transaction on the req_ side carries one received byte and the current
// duty readback. Ordinary bytes are stored (at most LINE_BYTES-1 of them,
// further bytes are dropped) and the block stays ready for the next byte. A
// CR or LF on a non-empty line starts a scan that reads the line store one
// byte per cycle through its single registered read port. Once the scan ends,
// the response characters are loaded into the output register one by one,
// each while the register is empty or the rsp_ side takes the previous one.
// A whitespace-only line answers "empty" (no CR LF), a valid SET PWM answers
// "OK" CR LF with set_strobe and set_value on the first character, GET PWM
// answers the readback in decimal and CR LF, and anything else produces no
// response transaction. The last character of each response is marked with
// rsp_tlast. The final response character may sit in the output register
// while the next byte is accepted.
// ----------------------------------------------------------------------------
module pwm_text_command_parser #(
   parameter int LINE_BYTES = pwmcp_pkg::LINE_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] rx_byte, [15:8] duty_readback
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] tx_byte, [8] set_strobe, [15:9] set_value
   output logic [0:0]  rsp_tuser,   // [0] has_byte
   output logic        rsp_tlast
);
   import pwmcp_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller sequences byte intake, the scan and the response.
   pwmcp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rx_byte    (req_tdata[7:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // The datapath holds the line, parses it and builds response characters.
   pwmcp_dp #(
      .LINE_BYTES (LINE_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule
